@@ hw/rtl/a64dpi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// A64 data-processing-immediate execute package
// Shared widths, decode codes and the result record of the execute unit.
// ----------------------------------------------------------------------------
package a64dpi_pkg;

    // Register file geometry.
    localparam int NumRegs   = 31;
    localparam int RegIdxW   = 5;
    localparam int DataW     = 64;
    localparam int HalfW     = 32;
    localparam int InsnW     = 32;
    localparam int FlagsW    = 4;

    // Register number that reads as zero and swallows writes.
    localparam logic [RegIdxW-1:0] ZeroReg = 5'd31;

    // Instruction group codes, bits 25..23.
    localparam logic [2:0] GroupAddSub   = 3'b010;
    localparam logic [2:0] GroupWideMove = 3'b101;

    // Wide-move opc codes, bits 30..29.
    localparam logic [1:0] OpcMovN     = 2'b00;
    localparam logic [1:0] OpcReserved = 2'b01;
    localparam logic [1:0] OpcMovZ     = 2'b10;
    localparam logic [1:0] OpcMovK     = 2'b11;

    // Result word width.
    localparam int OutDataW = 80;

    // Outcome of executing one instruction.
    typedef struct packed {
        logic [DataW-1:0]  value;
        logic              did_write;
        logic [FlagsW-1:0] nzcv;
        logic              flags_changed;
        logic              error;
    } exec_result_t;

    // Register file read request and write port.
    typedef struct packed {
        logic               en;
        logic [RegIdxW-1:0] addr;
    } rf_read_t;

    typedef struct packed {
        logic               en;
        logic [RegIdxW-1:0] addr;
        logic [DataW-1:0]   data;
    } rf_write_t;

endpackage

@@ hw/rtl/a64dpi_regfile.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// A64 general register file
// 31 x 64-bit synchronous memory with one read and one write port, per-entry
// valid bits for the reset clear, and a bypass of the most recent write.
// ----------------------------------------------------------------------------
module a64dpi_regfile
    import a64dpi_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  rf_read_t         rd_req,
    input  rf_write_t        wr_req,
    output logic [DataW-1:0] rd_data
);

    logic [DataW-1:0]   mem [0:NumRegs-1];
    logic [NumRegs-1:0] valid_reg;
    logic [DataW-1:0]   rdata_reg;
    logic               rd_hit_reg;
    logic [RegIdxW-1:0] rd_addr_reg;
    logic               lw_valid_reg;
    logic [RegIdxW-1:0] lw_addr_reg;
    logic [DataW-1:0]   lw_data_reg;

    // Memory write port.
    always_ff @(posedge aclk) begin
        if (wr_req.en && (wr_req.addr != ZeroReg)) begin
            mem[wr_req.addr] <= wr_req.data;
        end
    end

    // Memory read port, data registered.
    always_ff @(posedge aclk) begin
        if (rd_req.en && (rd_req.addr != ZeroReg)) begin
            rdata_reg <= mem[rd_req.addr];
        end
    end

    // Valid bits: an entry never written since reset reads as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_req.en && (wr_req.addr != ZeroReg)) begin
            valid_reg[wr_req.addr] <= 1'b1;
        end
    end

    // Read qualifier, captured together with the read.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_hit_reg  <= 1'b0;
            rd_addr_reg <= ZeroReg;
        end else if (rd_req.en) begin
            rd_hit_reg  <= (rd_req.addr != ZeroReg) && valid_reg[rd_req.addr];
            rd_addr_reg <= rd_req.addr;
        end
    end

    // Last write, kept for forwarding to a read issued in the same cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lw_valid_reg <= 1'b0;
        end else if (wr_req.en) begin
            lw_valid_reg <= (wr_req.addr != ZeroReg);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_req.en) begin
            lw_addr_reg <= wr_req.addr;
            lw_data_reg <= wr_req.data;
        end
    end

    // The bypass wins over the memory, which may still hold the old value.
    always_comb begin
        if (lw_valid_reg && (lw_addr_reg == rd_addr_reg)) begin
            rd_data = lw_data_reg;
        end else if (rd_hit_reg) begin
            rd_data = rdata_reg;
        end else begin
            rd_data = '0;
        end
    end

endmodule

@@ hw/rtl/a64dpi_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// A64 immediate execute datapath
// Decodes one instruction and computes the add/sub or wide-move result and
// the new NZCV flags from the register operand and the current flags.
// ----------------------------------------------------------------------------
module a64dpi_alu
    import a64dpi_pkg::*;
(
    input  logic [InsnW-1:0]  insn,
    input  logic [DataW-1:0]  operand,
    input  logic [FlagsW-1:0] flags_in,
    output exec_result_t      result
);

    logic [RegIdxW-1:0] rd;
    logic [1:0]         opc;
    logic               sf;
    logic [2:0]         group;
    logic               is_sub;
    logic [DataW-1:0]   a_op;
    logic [DataW-1:0]   imm_as;
    logic [DataW:0]     sum;
    logic [DataW-1:0]   as_value;
    logic               n_flag;
    logic               z_flag;
    logic               c_flag;
    logic               v_flag;
    logic [DataW-1:0]   imm_wm;
    logic [DataW-1:0]   keep_wm;
    logic [DataW-1:0]   wm_value;
    logic [DataW-1:0]   raw_value;
    logic               is_addsub;
    logic               is_move;
    logic               set_flags;

    // Field decode.
    assign rd        = insn[4:0];
    assign opc       = insn[30:29];
    assign sf        = insn[31];
    assign group     = insn[25:23];
    assign is_sub    = opc[1];
    assign is_addsub = (group == GroupAddSub);
    assign is_move   = (group == GroupWideMove) && (opc != OpcReserved);
    assign set_flags = is_addsub && opc[0];

    // Add/sub: a single 65-bit adder; subtraction adds the inverted immediate.
    always_comb begin
        a_op   = sf ? operand : {{HalfW{1'b0}}, operand[HalfW-1:0]};
        imm_as = insn[22] ? {40'd0, insn[21:10], 12'd0} : {52'd0, insn[21:10]};
        sum    = {1'b0, a_op} + {1'b0, (is_sub ? ~imm_as : imm_as)}
                 + {{DataW{1'b0}}, is_sub};
        as_value = sf ? sum[DataW-1:0] : {{HalfW{1'b0}}, sum[HalfW-1:0]};
    end

    // NZCV at the operation width.
    always_comb begin
        n_flag = sf ? as_value[DataW-1] : as_value[HalfW-1];
        z_flag = (as_value == '0);
        if (is_sub) begin
            c_flag = sum[DataW];
            v_flag = sf ? ((a_op[DataW-1] ^ imm_as[DataW-1])
                           & (a_op[DataW-1] ^ as_value[DataW-1]))
                        : ((a_op[HalfW-1] ^ imm_as[HalfW-1])
                           & (a_op[HalfW-1] ^ as_value[HalfW-1]));
        end else begin
            c_flag = sf ? sum[DataW] : sum[HalfW];
            v_flag = sf ? ((a_op[DataW-1] ^ as_value[DataW-1])
                           & (imm_as[DataW-1] ^ as_value[DataW-1]))
                        : ((a_op[HalfW-1] ^ as_value[HalfW-1])
                           & (imm_as[HalfW-1] ^ as_value[HalfW-1]));
        end
    end

    // Wide move: place the 16-bit immediate at hw times 16.
    always_comb begin
        case (insn[22:21])
            2'd0: begin
                imm_wm  = {48'd0, insn[20:5]};
                keep_wm = 64'hFFFF_FFFF_FFFF_0000;
            end
            2'd1: begin
                imm_wm  = {32'd0, insn[20:5], 16'd0};
                keep_wm = 64'hFFFF_FFFF_0000_FFFF;
            end
            2'd2: begin
                imm_wm  = {16'd0, insn[20:5], 32'd0};
                keep_wm = 64'hFFFF_0000_FFFF_FFFF;
            end
            default: begin
                imm_wm  = {insn[20:5], 48'd0};
                keep_wm = 64'h0000_FFFF_FFFF_FFFF;
            end
        endcase
        case (opc)
            OpcMovN: wm_value = ~imm_wm;
            OpcMovZ: wm_value = imm_wm;
            OpcMovK: wm_value = (a_op & keep_wm) | imm_wm;
            default: wm_value = '0;
        endcase
    end

    // Result selection; a 32-bit form is zero-extended.
    always_comb begin
        if (is_addsub) begin
            raw_value = as_value;
        end else if (is_move) begin
            raw_value = sf ? wm_value : {{HalfW{1'b0}}, wm_value[HalfW-1:0]};
        end else begin
            raw_value = '0;
        end
        result.value         = raw_value;
        result.error         = !(is_addsub || is_move);
        result.did_write     = (is_addsub || is_move) && (rd != ZeroReg);
        result.flags_changed = set_flags;
        result.nzcv          = set_flags ? {n_flag, z_flag, c_flag, v_flag} : flags_in;
    end

endmodule

@@ hw/rtl/arm64_dp_immediate_exec_unit.sv @@
`timescale 1ns / 1ps
// An accepted word passes the execute stage, then the output register driving m_tdata.
// Throughput: one instruction per cycle unless the output stalls, set by the single read
// and write port of the register file; a back-to-back dependency uses the write bypass.
// Reset: synchronous active-low aresetn empties both stages, clears NZCV and marks all
// 31 registers invalid at once, so they read as zero until written; no clearing pass.
// ----------------------------------------------------------------------------
// A64 data-processing-immediate execute unit
// Two stages: register read issue on accept, then execute, write back and
// load of the output register, which decouples the result stream.
// ----------------------------------------------------------------------------
module arm64_dp_immediate_exec_unit
    import a64dpi_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [InsnW-1:0]    s_tdata,   // [31:0] instruction
    output logic                m_tvalid,
    input  logic                m_tready,
    // [4:0] dest_index, [68:5] write_value, [69] did_write, [73:70] flags_nzcv,
    // [74] flags_changed, [75] error, [79:76] zero
    output logic [OutDataW-1:0] m_tdata
);

    logic               s_accept;
    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic [InsnW-1:0]   s1_insn_reg;
    logic               s1_advance;
    logic [FlagsW-1:0]  flags_reg;
    logic               m_valid_reg;
    logic               m_valid_next;
    logic [OutDataW-1:0] m_data_reg;
    logic [DataW-1:0]   operand;
    rf_read_t           rd_req;
    rf_write_t          wr_req;
    exec_result_t       result;

    // Handshake: the execute stage moves on whenever the output register frees.
    assign s1_advance = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready   = !s1_valid_reg || s1_advance;
    assign s_accept   = s_tvalid && s_tready;

    // Read Rn for add/sub, Rd for the kept bits of MOVK.
    assign rd_req.en   = s_accept;
    assign rd_req.addr = (s_tdata[25:23] == GroupAddSub) ? s_tdata[9:5] : s_tdata[4:0];

    // Write back on leaving the execute stage.
    assign wr_req.en   = s1_advance && result.did_write;
    assign wr_req.addr = s1_insn_reg[4:0];
    assign wr_req.data = result.value;

    a64dpi_regfile u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_req  (rd_req),
        .wr_req  (wr_req),
        .rd_data (operand)
    );

    a64dpi_alu u_alu (
        .insn     (s1_insn_reg),
        .operand  (operand),
        .flags_in (flags_reg),
        .result   (result)
    );

    // Execute stage occupancy.
    always_comb begin
        if (s_accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_advance) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_insn_reg <= s_tdata;
        end
    end

    // Condition flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
        end else if (s1_advance) begin
            flags_reg <= result.nzcv;
        end
    end

    // Output register occupancy.
    always_comb begin
        if (s1_advance) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            m_data_reg <= {4'd0, result.error, result.flags_changed, result.nzcv,
                           result.did_write, result.value, s1_insn_reg[4:0]};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

@@ hw/rtl/a64dpi_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// A64 execute unit port checker
// Watches the stream ports of the execute unit and checks result word rules.
// ----------------------------------------------------------------------------
module a64dpi_checker
    import a64dpi_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [OutDataW-1:0] m_tdata
);

    // A stalled result word holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // Reset empties the output.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // An accepted word is followed by a valid output word, its own or one still stalled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> ##1 m_tvalid)
        else $error("accepted word produced no result");

    // An error writes nothing, changes no flags and reports a zero value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[75] |-> !m_tdata[69] && !m_tdata[74] && (m_tdata[68:5] == '0))
        else $error("error result carries a write");

    // The zero register is never written.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[69] |-> (m_tdata[4:0] != ZeroReg))
        else $error("write reported to the zero register");

endmodule

bind arm64_dp_immediate_exec_unit a64dpi_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ verif/arm64_dp_immediate_exec_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// A64 data-processing-immediate execute unit testbench
// Drives instruction words into the unit and keeps its own register file and
// NZCV copy to work out each retired word. A directed table covers the
// extremes and special cases, then random add/sub and wide-move words follow,
// mixed with raw noise, under random bursts on the input and random stalls
// on the output.
// ----------------------------------------------------------------------------
module arm64_dp_immediate_exec_unit_test;
    import a64dpi_pkg::*;

    localparam int ClkPeriod     = 10;
    localparam int ResetCycles   = 7;
    localparam int RandomWords   = 950;
    localparam int HoldOffCycles = 250;
    localparam int WatchdogLimit = 1000;
    localparam int DrainCycles   = 4;

    // Add/sub immediate opc values, bits 30..29.
    localparam logic [1:0] OpAdd  = 2'b00;
    localparam logic [1:0] OpAdds = 2'b01;
    localparam logic [1:0] OpSub  = 2'b10;
    localparam logic [1:0] OpSubs = 2'b11;

    // One retired instruction as it leaves the unit.
    typedef struct packed {
        logic [RegIdxW-1:0] rd;
        logic [DataW-1:0]   value;
        logic               did_write;
        logic [FlagsW-1:0]  nzcv;
        logic               flags_changed;
        logic               error;
    } retire_rec_t;

    // One row of the directed table.
    typedef struct {
        logic [InsnW-1:0] insn;
        bit               typed;
        retire_rec_t      want;
    } stim_row_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [InsnW-1:0]    s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [OutDataW-1:0] m_tdata;

    // Shadow architectural state.
    logic [DataW-1:0]  gpr [NumRegs];
    logic [FlagsW-1:0] nzcv_flags;

    retire_rec_t retire_q [$];
    stim_row_t   dir_rows [$];
    retire_rec_t cur_want;
    bit          cur_typed;
    logic        hold_off_req;
    int          in_words;
    int          stall_cycles;
    int          fail_count;
    int          burst_left;

    arm64_dp_immediate_exec_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #(ClkPeriod / 2) aclk = ~aclk;

    function automatic logic [InsnW-1:0] enc_addsub(logic sf, logic [1:0] op, logic sh,
                                                    logic [11:0] imm12, logic [4:0] rn,
                                                    logic [4:0] rd);
        return {sf, op, 3'b100, GroupAddSub, sh, imm12, rn, rd};
    endfunction

    function automatic logic [InsnW-1:0] enc_move(logic sf, logic [1:0] opc, logic [1:0] hw,
                                                  logic [15:0] imm16, logic [4:0] rd);
        return {sf, opc, 3'b100, GroupWideMove, hw, imm16, rd};
    endfunction

    // Register 31 reads as zero; a 32-bit read sees only the low half.
    function automatic logic [DataW-1:0] read_gpr(logic [RegIdxW-1:0] r, logic wide);
        logic [DataW-1:0] v;
        v = (r == ZeroReg) ? '0 : gpr[r];
        return wide ? v : {32'd0, v[HalfW-1:0]};
    endfunction

    // Executes one instruction on the shadow state and returns its retirement.
    function automatic retire_rec_t execute_insn(logic [InsnW-1:0] insn);
        retire_rec_t      r;
        logic [DataW-1:0] a;
        logic [DataW-1:0] imm;
        logic [DataW-1:0] raw;
        logic             wide;
        logic             n, z, c, v;
        int               top;
        int               sh;
        r = '0;
        r.rd = insn[4:0];
        wide = insn[31];
        top = wide ? DataW - 1 : HalfW - 1;
        if (insn[25:23] == GroupAddSub) begin
            imm = {52'd0, insn[21:10]};
            if (insn[22]) begin
                imm = imm << 12;
            end
            a = read_gpr(insn[9:5], wide);
            raw = insn[30] ? a - imm : a + imm;
            r.value = wide ? raw : {32'd0, raw[HalfW-1:0]};
            // The S forms set the flags at the operation width.
            if (insn[29]) begin
                n = r.value[top];
                z = (r.value == '0);
                if (insn[30]) begin
                    c = (a >= imm);
                    v = (a[top] ^ imm[top]) & (a[top] ^ r.value[top]);
                end else begin
                    c = wide ? (r.value < a) : raw[HalfW];
                    v = (a[top] ^ r.value[top]) & (imm[top] ^ r.value[top]);
                end
                nzcv_flags = {n, z, c, v};
                r.flags_changed = 1'b1;
            end
        end else if (insn[25:23] == GroupWideMove && insn[30:29] != OpcReserved) begin
            sh = 16 * int'(insn[22:21]);
            imm = {48'd0, insn[20:5]} << sh;
            case (insn[30:29])
                OpcMovN: r.value = ~imm;
                OpcMovZ: r.value = imm;
                default: r.value = (read_gpr(r.rd, wide) & ~(64'hFFFF << sh)) | imm;
            endcase
            if (!wide) begin
                r.value[DataW-1:HalfW] = '0;
            end
        end else begin
            r.error = 1'b1;
        end
        if (!r.error && r.rd != ZeroReg) begin
            gpr[r.rd] = r.value;
            r.did_write = 1'b1;
        end
        r.nzcv = nzcv_flags;
        return r;
    endfunction

    function automatic stim_row_t row_pred(logic [InsnW-1:0] insn);
        stim_row_t row;
        row.insn = insn;
        row.typed = 1'b0;
        row.want = '0;
        return row;
    endfunction

    function automatic stim_row_t row_known(logic [InsnW-1:0] insn, logic [4:0] rd,
                                            logic [63:0] value, logic wr, logic [3:0] nzcv,
                                            logic fchg, logic err);
        stim_row_t row;
        row.insn = insn;
        row.typed = 1'b1;
        row.want = {rd, value, wr, nzcv, fchg, err};
        return row;
    endfunction

    // Both channels are sampled at the rising edge; accepted instructions are
    // executed on the shadow state and retired words are checked in order.
    always @(posedge aclk) begin
        retire_rec_t pred;
        retire_rec_t exp_rec;
        retire_rec_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                pred = execute_insn(s_tdata);
                retire_q.push_back(cur_typed ? cur_want : pred);
                in_words++;
            end
            if (m_tvalid && m_tready) begin
                got = {m_tdata[4:0], m_tdata[68:5], m_tdata[69], m_tdata[73:70],
                       m_tdata[74], m_tdata[75]};
                if (retire_q.size() == 0) begin
                    $error("unexpected result word %h", m_tdata);
                    fail_count++;
                end else begin
                    exp_rec = retire_q.pop_front();
                    if (got.rd != exp_rec.rd) begin
                        $error("dest_index: expected %0d, got %0d", exp_rec.rd, got.rd);
                        fail_count++;
                    end
                    if (got.value != exp_rec.value) begin
                        $error("write_value: expected %h, got %h", exp_rec.value, got.value);
                        fail_count++;
                    end
                    if (got.did_write != exp_rec.did_write) begin
                        $error("did_write: expected %0b, got %0b",
                               exp_rec.did_write, got.did_write);
                        fail_count++;
                    end
                    if (got.nzcv != exp_rec.nzcv) begin
                        $error("flags_nzcv: expected %b, got %b", exp_rec.nzcv, got.nzcv);
                        fail_count++;
                    end
                    if (got.flags_changed != exp_rec.flags_changed) begin
                        $error("flags_changed: expected %0b, got %0b",
                               exp_rec.flags_changed, got.flags_changed);
                        fail_count++;
                    end
                    if (got.error != exp_rec.error) begin
                        $error("error: expected %0b, got %0b", exp_rec.error, got.error);
                        fail_count++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
    end

    // Watchdog on cycles with no word moving on either side.
    initial begin
        wait (stall_cycles >= WatchdogLimit);
        $display("[arm64_dp_immediate_exec_unit] ERROR");
        $finish;
    end

    // Receiver: segments of varying readiness, plus one long hold-off on request.
    initial begin
        int seg_left;
        int ready_pct;
        int hold_left;
        seg_left = 0;
        ready_pct = 100;
        hold_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_left = HoldOffCycles;
                hold_off_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready = 1'b0;
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(8, 60);
                    case ($urandom_range(0, 3))
                        0: ready_pct = 100;
                        1: ready_pct = 75;
                        2: ready_pct = 50;
                        default: ready_pct = 15;
                    endcase
                end
                seg_left--;
                m_tready = ($urandom_range(1, 100) <= ready_pct);
            end
        end
    end

    // Offers one word from a falling edge and returns on a falling edge once it
    // was taken; when the current burst ends, it may first insert an idle gap.
    task automatic send_word(logic [InsnW-1:0] insn, bit typed, retire_rec_t want);
        int taken0;
        int gap;
        s_tdata = insn;
        cur_typed = typed;
        cur_want = want;
        s_tvalid = 1'b1;
        taken0 = in_words;
        do @(negedge aclk); while (in_words == taken0);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end else begin
            burst_left--;
        end
    endtask

    // Random word: mostly well-formed add/sub or wide moves, some raw noise.
    function automatic logic [InsnW-1:0] random_insn();
        logic [InsnW-1:0] insn;
        logic [11:0]      imm12;
        logic [15:0]      imm16;
        int               pick;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 5))
            0: imm12 = '0;
            1: imm12 = '1;
            default: imm12 = 12'($urandom);
        endcase
        case ($urandom_range(0, 5))
            0: imm16 = '0;
            1: imm16 = '1;
            default: imm16 = 16'($urandom);
        endcase
        if (pick < 45) begin
            insn = enc_addsub(1'($urandom), 2'($urandom), 1'($urandom), imm12,
                              5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
        end else if (pick < 82) begin
            insn = enc_move(1'($urandom), 2'($urandom), 2'($urandom), imm16,
                            5'($urandom_range(0, 31)));
        end else begin
            insn = $urandom;
        end
        if (pick < 82) begin
            insn[28:26] = 3'($urandom);
        end
        return insn;
    endfunction

    initial begin
        retire_rec_t none;
        none = '0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cur_typed = 1'b0;
        cur_want = '0;
        hold_off_req = 1'b0;
        in_words = 0;
        stall_cycles = 0;
        fail_count = 0;
        burst_left = 0;
        nzcv_flags = '0;
        foreach (gpr[i]) begin
            gpr[i] = '0;
        end

        // Directed table; the first rows start from the cleared state.
        dir_rows.push_back(row_known(enc_addsub(1'b1, OpAdd, 1'b0, 12'h000, ZeroReg, 5'd0),
                                     5'd0, 64'd0, 1'b1, 4'b0000, 1'b0, 1'b0));
        dir_rows.push_back(row_known(enc_addsub(1'b1, OpAdds, 1'b1, 12'hFFF, ZeroReg, 5'd1),
                                     5'd1, 64'h0000_0000_00FF_F000, 1'b1, 4'b0000, 1'b1,
                                     1'b0));
        dir_rows.push_back(row_known(enc_addsub(1'b0, OpSubs, 1'b0, 12'h001, ZeroReg, 5'd2),
                                     5'd2, 64'h0000_0000_FFFF_FFFF, 1'b1, 4'b1000, 1'b1,
                                     1'b0));
        dir_rows.push_back(row_known(enc_addsub(1'b1, OpSubs, 1'b0, 12'h000, ZeroReg,
                                                ZeroReg),
                                     ZeroReg, 64'd0, 1'b0, 4'b0110, 1'b1, 1'b0));
        dir_rows.push_back(row_known(32'h0000_0000, 5'd0, 64'd0, 1'b0, 4'b0110, 1'b0, 1'b1));
        dir_rows.push_back(row_known(enc_move(1'b1, OpcReserved, 2'd0, 16'hFFFF, 5'd3),
                                     5'd3, 64'd0, 1'b0, 4'b0110, 1'b0, 1'b1));
        dir_rows.push_back(row_known(32'hFFFF_FFFF, ZeroReg, 64'd0, 1'b0, 4'b0110, 1'b0,
                                     1'b1));
        dir_rows.push_back(row_known(enc_move(1'b1, OpcMovZ, 2'd3, 16'hFFFF, 5'd4),
                                     5'd4, 64'hFFFF_0000_0000_0000, 1'b1, 4'b0110, 1'b0,
                                     1'b0));
        dir_rows.push_back(row_known(enc_move(1'b1, OpcMovN, 2'd0, 16'h0000, 5'd5),
                                     5'd5, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 4'b0110, 1'b0,
                                     1'b0));
        dir_rows.push_back(row_known(enc_move(1'b0, OpcMovN, 2'd0, 16'hFFFF, 5'd6),
                                     5'd6, 64'h0000_0000_FFFF_0000, 1'b1, 4'b0110, 1'b0,
                                     1'b0));
        dir_rows.push_back(row_known(enc_move(1'b0, OpcMovZ, 2'd3, 16'h1234, 5'd7),
                                     5'd7, 64'd0, 1'b1, 4'b0110, 1'b0, 1'b0));
        dir_rows.push_back(row_known(enc_move(1'b0, OpcMovN, 2'd2, 16'h1234, 5'd8),
                                     5'd8, 64'h0000_0000_FFFF_FFFF, 1'b1, 4'b0110, 1'b0,
                                     1'b0));
        // Keep-insert into a 64-bit value, and a 32-bit keep with hw beyond bit 31.
        dir_rows.push_back(row_pred(enc_move(1'b1, OpcMovK, 2'd0, 16'hABCD, 5'd4)));
        dir_rows.push_back(row_pred(enc_move(1'b0, OpcMovK, 2'd3, 16'h5555, 5'd5)));
        // Carry out to zero, signed overflow both ways, 32-bit carry on add and subtract.
        dir_rows.push_back(row_pred(enc_move(1'b1, OpcMovN, 2'd0, 16'h0000, 5'd10)));
        dir_rows.push_back(row_pred(enc_addsub(1'b1, OpAdds, 1'b0, 12'h001, 5'd10, 5'd11)));
        dir_rows.push_back(row_pred(enc_move(1'b1, OpcMovZ, 2'd3, 16'h8000, 5'd12)));
        dir_rows.push_back(row_pred(enc_addsub(1'b1, OpSubs, 1'b0, 12'h001, 5'd12, 5'd13)));
        dir_rows.push_back(row_pred(enc_move(1'b1, OpcMovN, 2'd3, 16'h8000, 5'd14)));
        dir_rows.push_back(row_pred(enc_addsub(1'b1, OpAdds, 1'b0, 12'h001, 5'd14, 5'd15)));
        dir_rows.push_back(row_pred(enc_addsub(1'b0, OpAdds, 1'b1, 12'hFFF, 5'd10, 5'd16)));
        dir_rows.push_back(row_pred(enc_addsub(1'b0, OpSubs, 1'b0, 12'hFFF, 5'd6, 5'd17)));
        dir_rows.push_back(row_pred(enc_addsub(1'b1, OpSub, 1'b0, 12'h001, ZeroReg, 5'd19)));
        // Zero register as destination: value reported, nothing stored.
        dir_rows.push_back(row_pred(enc_move(1'b1, OpcMovK, 2'd1, 16'h7777, ZeroReg)));
        dir_rows.push_back(row_pred(enc_addsub(1'b1, OpAdds, 1'b1, 12'h800, 5'd4, ZeroReg)));

        repeat (ResetCycles) @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_rows[i]) begin
            send_word(dir_rows[i].insn, dir_rows[i].typed, dir_rows[i].want);
        end

        for (int i = 0; i < RandomWords; i++) begin
            // Long output stall while the input keeps offering words.
            if (i == 300) begin
                hold_off_req = 1'b1;
            end
            // Input pause until every retired word has come out.
            if (i == 650) begin
                s_tvalid = 1'b0;
                while (retire_q.size() != 0) @(negedge aclk);
            end
            send_word(random_insn(), 1'b0, none);
        end
        s_tvalid = 1'b0;

        while (retire_q.size() != 0) @(negedge aclk);
        repeat (DrainCycles) @(negedge aclk);

        if (fail_count == 0 && retire_q.size() == 0) begin
            $display("[arm64_dp_immediate_exec_unit] OK");
        end else begin
            $display("[arm64_dp_immediate_exec_unit] ERROR");
        end
        $finish;
    end

endmodule
